[design/hvs_pkg.sv]
// Shared types, constants and lookup functions for the HTTP version sniffer.
`timescale 1ns / 1ps
`default_nettype none

package hvs_pkg;

   // byte counter, saturating
   localparam int unsigned COUNT_W = 25;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // text prefix before the second CRLF
   localparam int unsigned PREFIX_LIMIT = 64;
   localparam int unsigned TEXT_W = 7;
   localparam logic [TEXT_W-1:0] TEXT_MAX = {TEXT_W{1'b1}};
   localparam logic [COUNT_W-1:0] CLOSE_POS = COUNT_W'(PREFIX_LIMIT + 1);

   // HTTP/2 frame header and preface
   localparam int unsigned HDR_LEN = 9;
   localparam int unsigned HDR_IDX_W = 4;
   localparam int unsigned PREFACE_LEN = 24;
   localparam int unsigned PREFACE_IDX_W = 5;
   localparam logic [PREFACE_LEN*8-1:0] PREFACE_TEXT = {
      "PRI * HTTP/2.0", 8'h0d, 8'h0a, 8'h0d, 8'h0a, "SM", 8'h0d, 8'h0a, 8'h0d, 8'h0a
   };

   localparam logic [7:0] FRAME_RST_STREAM    = 8'h03;
   localparam logic [7:0] FRAME_SETTINGS      = 8'h04;
   localparam logic [7:0] FRAME_PING          = 8'h06;
   localparam logic [7:0] FRAME_WINDOW_UPDATE = 8'h08;

   localparam logic [7:0] ASCII_CR = 8'h0d;
   localparam logic [7:0] ASCII_LF = 8'h0a;

   // HTTP/1.1 text matchers
   localparam int unsigned METHOD_COUNT = 6;
   localparam int unsigned RESP_LEN = 5;
   localparam logic [63:0] VERSION_WORD = "http/1.1";
   localparam logic [RESP_LEN*8-1:0] RESP_TEXT = "http/";

   typedef enum logic [1:0] {
      PROTO_UNKNOWN = 2'd0,
      PROTO_HTTP2   = 2'd1,
      PROTO_HTTP11  = 2'd2
   } proto_type;

   typedef enum logic [2:0] {
      RULE_NONE          = 3'd0,
      RULE_PREFACE       = 3'd1,
      RULE_SETTINGS      = 3'd2,
      RULE_PING          = 3'd3,
      RULE_RST_STREAM    = 3'd4,
      RULE_WINDOW_UPDATE = 3'd5,
      RULE_REQUEST       = 3'd6,
      RULE_RESPONSE      = 3'd7
   } rule_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } item_type;

   typedef struct packed {
      rule_type  rule;
      proto_type protocol;
   } result_type;

   function automatic logic [7:0] preface_byte(input logic [PREFACE_IDX_W-1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (32'(idx) < PREFACE_LEN) begin
         b = PREFACE_TEXT[(PREFACE_LEN - 1 - 32'(idx))*8 +: 8];
      end
      return b;
   endfunction

   function automatic logic [63:0] method_word(input logic [2:0] m);
      logic [63:0] w;
      unique case (m)
         3'd0:    w = {"get ", 32'h0};
         3'd1:    w = {"post ", 24'h0};
         3'd2:    w = {"put ", 32'h0};
         3'd3:    w = {"delete ", 8'h0};
         3'd4:    w = {"head ", 24'h0};
         3'd5:    w = "options ";
         default: w = 64'h0;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] method_len(input logic [2:0] m);
      logic [3:0] n;
      unique case (m)
         3'd0:    n = 4'd4;
         3'd1:    n = 4'd5;
         3'd2:    n = 4'd4;
         3'd3:    n = 4'd7;
         3'd4:    n = 4'd5;
         3'd5:    n = 4'd8;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] method_char(input logic [2:0] m, input logic [2:0] p);
      logic [63:0] w;
      w = method_word(m);
      return w[(7 - 32'(p))*8 +: 8];
   endfunction

   function automatic logic [7:0] resp_char(input logic [2:0] p);
      logic [7:0] c;
      unique case (p)
         3'd0:    c = RESP_TEXT[39:32];
         3'd1:    c = RESP_TEXT[31:24];
         3'd2:    c = RESP_TEXT[23:16];
         3'd3:    c = RESP_TEXT[15:8];
         3'd4:    c = RESP_TEXT[7:0];
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
   endfunction

endpackage

`default_nettype wire

[design/http_version_sniffer_unit.sv]
// Top level of the HTTP version sniffer: input register, classifier core, result register.
// A closing word (tlast) is judged on its way from input register to result register.
// Throughput: one request word per cycle, a closing word only when the result register has
//   room; the per-byte update and the verdict sit in one combinational step between them.
// Reset: synchronous, active high; empties both registers and returns all matcher state
//   to its start values. Frame header bytes hold no reset value and are read only after
//   nine bytes of a message have been written.
`timescale 1ns / 1ps
`default_nettype none

module http_version_sniffer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream: one connection byte per word
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] has_byte (0 only for a word that carries no byte)
   input  wire logic        req_tlast,   // closes the message and triggers the verdict
   // response stream: one verdict word per message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // [1:0] protocol, [4:2] rule, [7:5] zero
);
   import hvs_pkg::*;

   item_type   item;
   logic       item_valid;
   logic       take;
   logic       out_free;
   logic       result_valid;
   result_type result;

   // input register; a word is taken whenever the register is empty or draining
   hvs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // matcher state; non-closing words never wait on the response side,
   // a closing word waits only until the result register has room
   hvs_core u_core (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .out_free     (out_free),
      .take         (take),
      .result_valid (result_valid),
      .result       (result)
   );

   // result register parts the response handshake from the core
   hvs_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .out_free     (out_free),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

`default_nettype wire

[design/hvs_in_stage.sv]
// Input register: holds one accepted request word until the core consumes it.
`timescale 1ns / 1ps
`default_nettype none

module hvs_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // [7:0] data_byte
   input  wire logic              req_tuser,   // [0] has_byte
   input  wire logic              req_tlast,
   input  wire logic              take,
   output logic                   item_valid,
   output hvs_pkg::item_type      item
);
   import hvs_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= '{data_byte: req_tdata, has_byte: req_tuser, last: req_tlast};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

[design/hvs_core.sv]
// Sniffer state and per-byte update, with the verdict on the closing word.
`timescale 1ns / 1ps
`default_nettype none

module hvs_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire hvs_pkg::item_type  item,
   input  wire logic               out_free,
   output logic                    take,
   output logic                    result_valid,
   output hvs_pkg::result_type     result
);
   import hvs_pkg::*;

   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    preface_ff, preface_in;
   logic [7:0]              header_ff [HDR_LEN];
   logic [7:0]              header_in [HDR_LEN];
   logic [1:0]              phase_ff, phase_in;
   logic                    prev_cr_ff, prev_cr_in;
   logic [7:0]              held_ff, held_in;
   logic                    held_valid_ff, held_valid_in;
   logic                    trimming_ff, trimming_in;
   logic [TEXT_W-1:0]       text_pos_ff, text_pos_in;
   logic [METHOD_COUNT-1:0] mask_ff, mask_in;
   logic                    resp_ff, resp_in;
   logic                    line_open_ff, line_open_in;
   logic [63:0]             window_ff, window_in;
   logic                    seen_ff, seen_in;
   logic                    closed_ff, closed_in;

   logic [COUNT_W-1:0]      pos;
   logic [7:0]              b;
   logic [7:0]              low_char;
   logic                    second;
   logic                    clear;

   assign take  = item_valid && (!item.last || out_free);
   assign clear = take && item.last;
   assign b     = item.data_byte;
   assign pos   = count_ff;

   // per-byte update
   always_comb begin
      count_in      = count_ff;
      preface_in    = preface_ff;
      header_in     = header_ff;
      phase_in      = phase_ff;
      prev_cr_in    = prev_cr_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      trimming_in   = trimming_ff;
      text_pos_in   = text_pos_ff;
      mask_in       = mask_ff;
      resp_in       = resp_ff;
      line_open_in  = line_open_ff;
      window_in     = window_ff;
      seen_in       = seen_ff;
      closed_in     = closed_ff;
      second        = 1'b0;
      low_char      = to_lower(held_ff);

      if (take && item.has_byte) begin
         if (pos < COUNT_W'(HDR_LEN)) begin
            header_in[pos[HDR_IDX_W-1:0]] = b;
         end
         if (pos < COUNT_W'(PREFACE_LEN) && preface_byte(pos[PREFACE_IDX_W-1:0]) != b) begin
            preface_in = 1'b0;
         end
         if (prev_cr_ff && b == ASCII_LF) begin
            if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
            end else if (phase_ff == 2'd1) begin
               phase_in = 2'd2;
               second   = 1'b1;
            end
         end

         // text matchers run one byte behind
         if (held_valid_ff && !closed_ff) begin
            if (second || pos >= CLOSE_POS) begin
               closed_in = 1'b1;
            end else if (!(trimming_ff && is_space(held_ff))) begin
               trimming_in = 1'b0;
               for (int i = 0; i < METHOD_COUNT; i++) begin
                  if (text_pos_ff < TEXT_W'(method_len(3'(i))) &&
                      method_char(3'(i), text_pos_ff[2:0]) != low_char) begin
                     mask_in[i] = 1'b0;
                  end
               end
               if (text_pos_ff < TEXT_W'(RESP_LEN) && resp_char(text_pos_ff[2:0]) != low_char) begin
                  resp_in = 1'b0;
               end
               if (line_open_ff) begin
                  if (text_pos_ff != '0 && window_ff[7:0] == ASCII_CR && low_char == ASCII_LF) begin
                     line_open_in = 1'b0;
                  end else begin
                     window_in = {window_ff[55:0], low_char};
                     if (window_in == VERSION_WORD) begin
                        seen_in = 1'b1;
                     end
                  end
               end
               if (text_pos_ff < TEXT_MAX) begin
                  text_pos_in = text_pos_ff + TEXT_W'(1);
               end
            end
         end

         held_in       = b;
         held_valid_in = 1'b1;
         prev_cr_in    = (b == ASCII_CR);
         if (count_ff < COUNT_MAX) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   // verdict on the updated state
   logic [23:0]        frame_len;
   logic [7:0]         frame_kind;
   logic               stream_zero;
   logic               size_match;
   logic [METHOD_COUNT-1:0] reached;
   logic               method_hit;

   always_comb begin
      frame_len   = {header_in[0], header_in[1], header_in[2]};
      frame_kind  = header_in[3];
      stream_zero = ({header_in[5][6:0], header_in[6], header_in[7], header_in[8]} == 31'd0);
      size_match  = !header_in[5][7] &&
                    (count_in == {1'b0, frame_len} + COUNT_W'(HDR_LEN));
      for (int i = 0; i < METHOD_COUNT; i++) begin
         reached[i] = text_pos_in >= TEXT_W'(method_len(3'(i)));
      end
      method_hit = |(mask_in & reached);

      result.protocol = PROTO_UNKNOWN;
      result.rule     = RULE_NONE;
      if (count_in == '0) begin
         result.protocol = PROTO_UNKNOWN;
      end else if (count_in >= COUNT_W'(PREFACE_LEN) && preface_in) begin
         result.protocol = PROTO_HTTP2;
         result.rule     = RULE_PREFACE;
      end else begin
         if (count_in >= COUNT_W'(HDR_LEN) && size_match) begin
            priority if (frame_kind == FRAME_SETTINGS && stream_zero) begin
               result.rule = RULE_SETTINGS;
            end else if (frame_kind == FRAME_PING && stream_zero) begin
               result.rule = RULE_PING;
            end else if (frame_kind == FRAME_RST_STREAM && !stream_zero) begin
               result.rule = RULE_RST_STREAM;
            end else if (frame_kind == FRAME_WINDOW_UPDATE) begin
               result.rule = RULE_WINDOW_UPDATE;
            end
            if (result.rule != RULE_NONE) begin
               result.protocol = PROTO_HTTP2;
            end
         end
         if (result.protocol == PROTO_UNKNOWN && phase_in == 2'd2) begin
            if (method_hit) begin
               if (seen_in) begin
                  result.protocol = PROTO_HTTP11;
                  result.rule     = RULE_REQUEST;
               end
            end else if (resp_in && text_pos_in >= TEXT_W'(RESP_LEN)) begin
               result.protocol = PROTO_HTTP11;
               result.rule     = RULE_RESPONSE;
            end
         end
      end
   end

   assign result_valid = clear;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         count_ff      <= '0;
         preface_ff    <= 1'b1;
         phase_ff      <= 2'd0;
         prev_cr_ff    <= 1'b0;
         held_ff       <= 8'h00;
         held_valid_ff <= 1'b0;
         trimming_ff   <= 1'b1;
         text_pos_ff   <= '0;
         mask_ff       <= '1;
         resp_ff       <= 1'b1;
         line_open_ff  <= 1'b1;
         window_ff     <= 64'h0;
         seen_ff       <= 1'b0;
         closed_ff     <= 1'b0;
      end else begin
         count_ff      <= count_in;
         preface_ff    <= preface_in;
         phase_ff      <= phase_in;
         prev_cr_ff    <= prev_cr_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         trimming_ff   <= trimming_in;
         text_pos_ff   <= text_pos_in;
         mask_ff       <= mask_in;
         resp_ff       <= resp_in;
         line_open_ff  <= line_open_in;
         window_ff     <= window_in;
         seen_ff       <= seen_in;
         closed_ff     <= closed_in;
      end
   end

   // frame header bytes, only read once all nine are written
   always_ff @(posedge clock) begin
      header_ff <= header_in;
   end

endmodule

`default_nettype wire

[design/hvs_out_stage.sv]
// Result register: holds one verdict word until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module hvs_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 result_valid,
   input  wire hvs_pkg::result_type  result,
   output logic                      out_free,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata    // [1:0] protocol, [4:2] rule, [7:5] zero
);
   import hvs_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (result_valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000, data_ff.rule, data_ff.protocol};

endmodule

`default_nettype wire

[design/hvs_checker.sv]
// Port-level checks for the HTTP version sniffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hvs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);
   import hvs_pkg::*;

   // response register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   // padding zero and protocol code in range
   a_rsp_format: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:5] == 3'b000 && rsp_tdata[1:0] != 2'd3)
      else $error("malformed response word");

   // unknown protocol carries no rule
   a_unknown_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == PROTO_UNKNOWN |-> rsp_tdata[4:2] == RULE_NONE)
      else $error("rule set on unknown protocol");

   // HTTP/1.1 verdicts come only from the text rules
   a_http11_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == PROTO_HTTP11 |->
         rsp_tdata[4:2] == RULE_REQUEST || rsp_tdata[4:2] == RULE_RESPONSE)
      else $error("HTTP/1.1 verdict with a frame rule");

endmodule

bind http_version_sniffer_unit hvs_checker u_hvs_checker (.*);

`default_nettype wire
